// ----- design/cbb_pkg.sv -----
// shared types, codes and helpers of the cell buffer blit engine
package cbb_pkg;

   localparam int CHAR_BITS = 8;
   localparam int ATTR_PORT_BITS = 24;
   localparam int SIZE_BITS = 12;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] KIND_READ = 3'd0;
   localparam logic [2:0] KIND_WRITE = 3'd1;
   localparam logic [2:0] KIND_FILL = 3'd2;
   localparam logic [2:0] KIND_CLEAR = 3'd3;
   localparam logic [2:0] KIND_BLIT = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OOB = 2'd1;
   localparam logic [1:0] STATUS_SKIP = 2'd2;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ORIGIN_X = 2'd2;
   localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] col;
      logic [7:0] row;
      logic [CHAR_BITS-1:0] cell_char;
      logic [ATTR_PORT_BITS-1:0] cell_attr;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] read_char;
      logic [ATTR_PORT_BITS-1:0] read_attr;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [8:0] buffer_width;
      logic [8:0] buffer_height;
      logic [7:0] blit_origin_x;
      logic [7:0] blit_origin_y;
   } cfg_type;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [8:0] value,
                                                       input logic [SIZE_BITS-1:0] max_size);
      logic [SIZE_BITS-1:0] wide;
      wide = SIZE_BITS'(value);
      if (wide == '0) begin
         return SIZE_BITS'(1);
      end else if (wide > max_size) begin
         return max_size;
      end else begin
         return wide;
      end
   endfunction

endpackage

// ----- design/cell_buffer_blit_engine_unit.sv -----
// top level of the character cell frame buffer with color key blit
// Every transfer, fill and clear included, gives one result, which passes through the registered
// cell ram read stage and then the output register. With the result side never stalled and no
// sweep running, transfers are accepted one per cycle; a stalled result holds req_stall
// high once the output register and the read stage are both full. After a fill or clear is
// accepted, req_stall stays high while the sweeper writes the clamped width by clamped height
// area, one cell per cycle through the single ram write port. After reset the clearing pass
// writes all MAX_WIDTH * MAX_HEIGHT cells while req_stall stays high; configuration writes
// are taken at any time.
module cell_buffer_blit_engine_unit #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int ATTR_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cbb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cbb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [cbb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [cbb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = CW + RW;
   localparam int DW = cbb_pkg::CHAR_BITS + ATTR_BITS;
   localparam int SB = cbb_pkg::SIZE_BITS;

   cbb_pkg::cfg_type cfg;

   logic          accept;
   logic          sweep_busy;
   logic          sweep_start;
   logic [AW-1:0] sweep_addr;
   logic [DW-1:0] sweep_data;

   logic [SB-1:0] eff_w;
   logic [SB-1:0] eff_h;
   logic [SB-1:0] w_m1;
   logic [SB-1:0] h_m1;
   logic [SB-1:0] cx;
   logic [SB-1:0] cy;
   logic          inb;
   logic [AW-1:0] item_addr;
   logic [ATTR_BITS+cbb_pkg::ATTR_PORT_BITS-1:0] attr_ext;
   logic [DW-1:0] item_cell;
   logic          item_wr;
   logic          item_rd;
   logic [1:0]    item_status;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [DW-1:0] mem_wr_data;
   logic [DW-1:0] mem_rd_data;
   logic [ATTR_BITS+cbb_pkg::ATTR_PORT_BITS-1:0] rd_attr_ext;

   logic          s1_valid_ff;
   logic          s1_rd_ff;
   logic [1:0]    s1_status_ff;
   logic          s1_move;
   logic          out_valid_ff;
   cbb_pkg::rsp_type out_ff;
   cbb_pkg::rsp_type out_in;

   cbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign eff_w = cbb_pkg::clamp_size(cfg.buffer_width, SB'(MAX_WIDTH));
   assign eff_h = cbb_pkg::clamp_size(cfg.buffer_height, SB'(MAX_HEIGHT));
   assign w_m1 = eff_w - SB'(1);
   assign h_m1 = eff_h - SB'(1);

   always_comb begin
      if (req_data.kind == cbb_pkg::KIND_BLIT) begin
         cx = SB'(cfg.blit_origin_x) + SB'(req_data.col);
         cy = SB'(cfg.blit_origin_y) + SB'(req_data.row);
      end else begin
         cx = SB'(req_data.col);
         cy = SB'(req_data.row);
      end
   end

   assign inb = (cx < eff_w) && (cy < eff_h);
   assign item_addr = {cy[RW-1:0], cx[CW-1:0]};
   assign attr_ext = {ATTR_BITS'(0), req_data.cell_attr};
   assign item_cell = {attr_ext[ATTR_BITS-1:0], req_data.cell_char};

   always_comb begin
      item_wr = 1'b0;
      item_rd = 1'b0;
      item_status = cbb_pkg::STATUS_OK;
      case (req_data.kind)
         cbb_pkg::KIND_READ: begin
            item_rd = inb;
            item_status = inb ? cbb_pkg::STATUS_OK : cbb_pkg::STATUS_OOB;
         end
         cbb_pkg::KIND_WRITE: begin
            item_wr = inb;
            item_status = inb ? cbb_pkg::STATUS_OK : cbb_pkg::STATUS_OOB;
         end
         cbb_pkg::KIND_BLIT: begin
            if (!inb) begin
               item_status = cbb_pkg::STATUS_OOB;
            end else if (req_data.cell_char == '0) begin
               item_status = cbb_pkg::STATUS_SKIP;
            end else begin
               item_wr = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign s1_move = !out_valid_ff || !rsp_stall;
   assign req_stall = sweep_busy || (s1_valid_ff && !s1_move);
   assign accept = req_valid && !req_stall;
   assign sweep_start = accept && ((req_data.kind == cbb_pkg::KIND_FILL) ||
                                   (req_data.kind == cbb_pkg::KIND_CLEAR));

   cbb_sweep #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW),
      .DW         (DW)
   ) u_sweep (
      .clock          (clock),
      .reset          (reset),
      .start          (sweep_start),
      .start_last_col (w_m1[CW-1:0]),
      .start_last_row (h_m1[RW-1:0]),
      .start_value    ((req_data.kind == cbb_pkg::KIND_FILL) ? item_cell : DW'(0)),
      .busy           (sweep_busy),
      .wr_addr        (sweep_addr),
      .wr_data        (sweep_data)
   );

   assign mem_wr_en = sweep_busy || (accept && item_wr);
   assign mem_wr_addr = sweep_busy ? sweep_addr : item_addr;
   assign mem_wr_data = sweep_busy ? sweep_data : item_cell;

   cbb_ram #(
      .WIDTH (DW),
      .DEPTH (2 ** AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept && item_rd),
      .rd_addr (item_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_attr_ext = {cbb_pkg::ATTR_PORT_BITS'(0), mem_rd_data[DW-1:cbb_pkg::CHAR_BITS]};

   always_comb begin
      out_in.status = s1_status_ff;
      if (s1_rd_ff) begin
         out_in.read_char = mem_rd_data[cbb_pkg::CHAR_BITS-1:0];
         out_in.read_attr = rd_attr_ext[cbb_pkg::ATTR_PORT_BITS-1:0];
      end else begin
         out_in.read_char = '0;
         out_in.read_attr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!s1_valid_ff || s1_move) begin
            s1_valid_ff <= accept;
         end
         if (s1_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff <= item_rd;
         s1_status_ff <= item_status;
      end
      if (s1_move && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// ----- design/cbb_ram.sv -----
// generic single write port, single read port ram with registered read
module cbb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cbb_csr.sv -----
// apb configuration registers
module cbb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cbb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [cbb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [cbb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                             csr_pready,
   output cbb_pkg::cfg_type                 cfg
);

   cbb_pkg::cfg_type cfg_ff;
   logic [1:0] reg_index;
   logic wr_transfer;

   assign reg_index = csr_paddr[3:2];
   assign wr_transfer = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_width <= 9'd256;
         cfg_ff.buffer_height <= 9'd256;
         cfg_ff.blit_origin_x <= 8'd0;
         cfg_ff.blit_origin_y <= 8'd0;
      end else if (wr_transfer) begin
         unique case (reg_index)
            cbb_pkg::REG_WIDTH: cfg_ff.buffer_width <= csr_pwdata[8:0];
            cbb_pkg::REG_HEIGHT: cfg_ff.buffer_height <= csr_pwdata[8:0];
            cbb_pkg::REG_ORIGIN_X: cfg_ff.blit_origin_x <= csr_pwdata[7:0];
            cbb_pkg::REG_ORIGIN_Y: cfg_ff.blit_origin_y <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         cbb_pkg::REG_WIDTH: csr_prdata = 32'(cfg_ff.buffer_width);
         cbb_pkg::REG_HEIGHT: csr_prdata = 32'(cfg_ff.buffer_height);
         cbb_pkg::REG_ORIGIN_X: csr_prdata = 32'(cfg_ff.blit_origin_x);
         cbb_pkg::REG_ORIGIN_Y: csr_prdata = 32'(cfg_ff.blit_origin_y);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

// ----- design/cbb_sweep.sv -----
// area sweeper that writes one cell per cycle for fill, clear and the reset pass
module cbb_sweep #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CW = 8,
   parameter int RW = 8,
   parameter int DW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CW-1:0]    start_last_col,
   input  logic [RW-1:0]    start_last_row,
   input  logic [DW-1:0]    start_value,
   output logic             busy,
   output logic [RW+CW-1:0] wr_addr,
   output logic [DW-1:0]    wr_data
);

   logic          busy_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] last_col_ff;
   logic [RW-1:0] last_row_ff;
   logic [DW-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         col_ff <= '0;
         row_ff <= '0;
         last_col_ff <= CW'(MAX_WIDTH - 1);
         last_row_ff <= RW'(MAX_HEIGHT - 1);
         value_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         col_ff <= '0;
         row_ff <= '0;
         last_col_ff <= start_last_col;
         last_row_ff <= start_last_row;
         value_ff <= start_value;
      end else if (busy_ff) begin
         if (col_ff == last_col_ff) begin
            col_ff <= '0;
            if (row_ff == last_row_ff) begin
               busy_ff <= 1'b0;
            end else begin
               row_ff <= row_ff + RW'(1);
            end
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   assign busy = busy_ff;
   assign wr_addr = {row_ff, col_ff};
   assign wr_data = value_ff;

endmodule
